// File: sv/sem_pkg.sv
// Package for the Sobel edge magnitude stream: payload structs, widths and
// the request type that runs through the square-root cell chain. No dependencies.
`default_nettype none
package sem_pkg;

    localparam int GRAY_W = 8;
    localparam int MAG_W  = 8;
    localparam int GRAD_W = 12;   // signed Gx / Gy, |G| <= 4*221
    localparam int SQ_W   = 20;   // one squared gradient
    localparam int RAD_W  = 22;   // Gx^2 + Gy^2, padded to an even width
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT_OUTPUT = 2'd2;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [MAG_W-1:0] MAG_MAX = 8'd255;

    typedef struct packed {
        logic       op;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic             frame_last;
    } result_t;

    // One request in flight through the root chain
    typedef struct packed {
        logic              valid;
        logic              emit;       // produces a result
        logic              border;     // forced to the border value
        logic              last;
        logic [RAD_W-1:0]  rad;        // radicand, consumed two bits per cell
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } cell_t;

endpackage
`default_nettype wire

// File: sv/sem_sqrt_cell.sv
// One cell of the floor square-root chain: resolves one root bit per cycle.
// Depends on sem_pkg.
`default_nettype none
module sem_sqrt_cell (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire sem_pkg::cell_t prev,
    output sem_pkg::cell_t      next
);

    logic [sem_pkg::REM_W+1:0] rem_x;
    logic [sem_pkg::REM_W+2:0] trial;
    sem_pkg::cell_t            cell_next;

    // Restoring digit step on the top two radicand bits
    always_comb
    begin
        rem_x = {prev.rem, prev.rad[sem_pkg::RAD_W-1 -: 2]};
        trial = {1'b0, rem_x} - {2'b00, prev.root, 2'b01};
        cell_next = prev;
        cell_next.rad = {prev.rad[sem_pkg::RAD_W-3:0], 2'b00};
        if (!trial[sem_pkg::REM_W+2])
        begin
            cell_next.rem  = trial[sem_pkg::REM_W-1:0];
            cell_next.root = {prev.root[sem_pkg::ROOT_W-2:0], 1'b1};
        end
        else
        begin
            cell_next.rem  = rem_x[sem_pkg::REM_W-1:0];
            cell_next.root = {prev.root[sem_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    // Hand the request to the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next <= '0;
        end
        else
        begin
            next <= cell_next;
        end
    end

endmodule
`default_nettype wire

// File: sv/sobel_edge_magnitude_stream.sv
// Top level of the Sobel edge magnitude stream: gray conversion, line stores,
// 3x3 window, gradient squares and the square-root cell chain. Uses sem_pkg, sem_sqrt_cell.
`default_nettype none
// Raster-order RGB pixels go in, one 8-bit edge magnitude per pixel comes out
// frame_width+1 pixels later; drain requests after the last pixel flush the
// border results still owed, the final one flagged frame_last. One request is
// in flight at a time: a pixel's result passes the line-store read, the
// gradient/square stage and the chain of 11 square-root cells (one root bit per
// cell) before it is offered. A request that gives no result frees the input
// once it leaves the last cell. The next request is taken while a result still
// waits in the output register. Configuration writes are taken at any time but
// must only be made while the block is idle.
module sobel_edge_magnitude_stream #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          pixel_valid,
    output      logic                          pixel_ready,
    input  wire sem_pkg::pixel_t               pixel,
    output      logic                          result_valid,
    input  wire logic                          result_ready,
    output      sem_pkg::result_t              result,
    input  wire logic                          cfg_valid,
    output      logic                          cfg_ready,
    input  wire logic [sem_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [sem_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int PW = $clog2(MAX_WIDTH + 2);
    localparam int NCELL = sem_pkg::ROOT_W;

    typedef struct packed {
        logic                       valid;
        logic                       pix;
        logic                       emit;
        logic                       border;
        logic                       last;
        logic [AW-1:0]              addr;
        logic [sem_pkg::GRAY_W-1:0] gray;
    } stage_t;

    // Configuration registers
    logic [11:0] frame_width_reg;
    logic [12:0] frame_height_reg;
    logic        invert_reg;

    // Position and pending counters
    logic [AW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [PW-1:0] pend_reg, pend_next;
    logic          busy_reg;

    logic [31:0] eff_w, eff_h;
    logic [31:0] c32, r32, pnew;
    logic        accept, frame_start, drain_ok, emit_now;
    logic [sem_pkg::GRAY_W-1:0] gray;

    stage_t s1_reg, s1_next, s2_reg;
    logic [sem_pkg::GRAY_W-1:0] win_reg [9];
    logic [sem_pkg::GRAY_W-1:0] up_rd_reg, mid_rd_reg;
    logic [sem_pkg::GRAY_W-1:0] upper_mem  [MAX_WIDTH];
    logic [sem_pkg::GRAY_W-1:0] middle_mem [MAX_WIDTH];

    logic signed [sem_pkg::GRAD_W-1:0] gx, gy;
    logic [sem_pkg::SQ_W-1:0] sqx_reg, sqy_reg;
    stage_t s3_reg;

    sem_pkg::cell_t chain [NCELL+1];
    logic [NCELL-1:0] chain_valid;

    logic                      fin_valid_reg;
    sem_pkg::result_t          fin_reg;
    logic                      out_valid_reg;
    sem_pkg::result_t          out_reg;
    logic                      fin_move, chain_done;
    logic [sem_pkg::MAG_W-1:0] root_sat;

    assign cfg_ready    = 1'b1;
    assign pixel_ready  = !busy_reg;
    assign accept       = pixel_valid && pixel_ready;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Clamped frame size
    always_comb
    begin
        eff_w = 32'(frame_width_reg);
        if (eff_w == 32'd0)
            eff_w = 32'd1;
        if (eff_w > 32'(MAX_WIDTH))
            eff_w = 32'(MAX_WIDTH);
        eff_h = 32'(frame_height_reg);
        if (eff_h == 32'd0)
            eff_h = 32'd1;
        if (eff_h > 32'(MAX_HEIGHT))
            eff_h = 32'(MAX_HEIGHT);
    end

    // Request decode: gray value, counter updates, whether a result is owed
    always_comb
    begin
        c32 = 32'(col_reg);
        r32 = 32'(row_reg);
        frame_start = (col_reg == '0) && (row_reg == '0);
        drain_ok    = frame_start && (pend_reg != '0);
        gray = sem_pkg::GRAY_W'({2'b00, pixel.red[7:2]})
             + sem_pkg::GRAY_W'({1'b0, pixel.green[7:1]})
             + sem_pkg::GRAY_W'({3'b000, pixel.blue[7:3]});
        pnew = (frame_start ? 32'd0 : 32'(pend_reg)) + 32'd1;
        emit_now = pnew > (eff_w + 32'd1);
        col_next  = col_reg;
        row_next  = row_reg;
        pend_next = pend_reg;
        s1_next = '0;
        s1_next.addr = col_reg;
        s1_next.gray = gray;
        if (accept)
        begin
            if (pixel.op == sem_pkg::OP_DRAIN)
            begin
                s1_next.valid  = 1'b1;
                s1_next.emit   = drain_ok;
                s1_next.border = 1'b1;
                s1_next.last   = (pend_reg == PW'(1));
                if (drain_ok)
                    pend_next = pend_reg - PW'(1);
            end
            else
            begin
                s1_next.valid  = 1'b1;
                s1_next.pix    = 1'b1;
                s1_next.emit   = emit_now;
                s1_next.border = !(r32 >= 32'd2 && c32 >= 32'd2 && c32 < eff_w && r32 < eff_h);
                pend_next = emit_now ? PW'(pnew - 32'd1) : PW'(pnew);
                if (c32 + 32'd1 >= eff_w)
                begin
                    col_next = '0;
                    row_next = (r32 + 32'd1 >= eff_h) ? '0 : row_reg + RW'(1);
                end
                else
                begin
                    col_next = col_reg + AW'(1);
                end
            end
        end
    end

    // Line stores: read at acceptance, rotate in the following cycle
    always_ff @(posedge clk)
    begin
        if (accept && pixel.op == sem_pkg::OP_PIXEL)
            up_rd_reg <= upper_mem[col_reg];
        if (s1_reg.valid && s1_reg.pix)
            upper_mem[s1_reg.addr] <= mid_rd_reg;
    end

    always_ff @(posedge clk)
    begin
        if (accept && pixel.op == sem_pkg::OP_PIXEL)
            mid_rd_reg <= middle_mem[col_reg];
        if (s1_reg.valid && s1_reg.pix)
            middle_mem[s1_reg.addr] <= s1_reg.gray;
    end

    // Gradients on the window, squared into registers
    always_comb
    begin
        gx = -$signed({4'b0, win_reg[0]}) + $signed({4'b0, win_reg[2]})
           - ($signed({4'b0, win_reg[3]}) <<< 1) + ($signed({4'b0, win_reg[5]}) <<< 1)
           - $signed({4'b0, win_reg[6]}) + $signed({4'b0, win_reg[8]});
        gy = -$signed({4'b0, win_reg[0]}) - ($signed({4'b0, win_reg[1]}) <<< 1)
           - $signed({4'b0, win_reg[2]}) + $signed({4'b0, win_reg[6]})
           + ($signed({4'b0, win_reg[7]}) <<< 1) + $signed({4'b0, win_reg[8]});
    end

    always_ff @(posedge clk)
    begin
        sqx_reg <= sem_pkg::SQ_W'($unsigned((2*sem_pkg::GRAD_W)'(gx)
                                            * (2*sem_pkg::GRAD_W)'(gx)));
        sqy_reg <= sem_pkg::SQ_W'($unsigned((2*sem_pkg::GRAD_W)'(gy)
                                            * (2*sem_pkg::GRAD_W)'(gy)));
    end

    // Chain entry
    always_comb
    begin
        chain[0].valid  = s3_reg.valid;
        chain[0].emit   = s3_reg.emit;
        chain[0].border = s3_reg.border;
        chain[0].last   = s3_reg.last;
        chain[0].rad    = sem_pkg::RAD_W'(sqx_reg) + sem_pkg::RAD_W'(sqy_reg);
        chain[0].rem    = '0;
        chain[0].root   = '0;
    end

    genvar gi;
    generate
        for (gi = 0; gi < NCELL; gi++)
        begin : g_cell
            sem_sqrt_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .prev  (chain[gi]),
                .next  (chain[gi+1])
            );
            assign chain_valid[gi] = chain[gi+1].valid;
        end
    endgenerate

    // Saturate at the chain end; border requests give zero
    always_comb
    begin
        root_sat = (chain[NCELL].root > sem_pkg::ROOT_W'(sem_pkg::MAG_MAX))
                 ? sem_pkg::MAG_MAX : chain[NCELL].root[sem_pkg::MAG_W-1:0];
        if (chain[NCELL].border)
            root_sat = '0;
        chain_done = chain[NCELL].valid;
        fin_move   = fin_valid_reg && (!out_valid_reg || result_ready);
    end

    // Window shift and result registers (payload)
    always_ff @(posedge clk)
    begin
        if (s1_reg.valid && s1_reg.pix)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i*3]   <= win_reg[i*3+1];
                win_reg[i*3+1] <= win_reg[i*3+2];
            end
            win_reg[2] <= up_rd_reg;
            win_reg[5] <= mid_rd_reg;
            win_reg[8] <= s1_reg.gray;
        end
        if (chain_done)
        begin
            fin_reg.magnitude  <= root_sat;
            fin_reg.frame_last <= chain[NCELL].last;
        end
        if (fin_move)
        begin
            out_reg.magnitude  <= invert_reg ? (sem_pkg::MAG_MAX - fin_reg.magnitude)
                                             : fin_reg.magnitude;
            out_reg.frame_last <= fin_reg.frame_last;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= 12'd640;
            frame_height_reg <= 13'd480;
            invert_reg       <= 1'b0;
            col_reg          <= '0;
            row_reg          <= '0;
            pend_reg         <= '0;
            busy_reg         <= 1'b0;
            s1_reg           <= '0;
            s2_reg           <= '0;
            s3_reg           <= '0;
            fin_valid_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    sem_pkg::REG_FRAME_WIDTH:   frame_width_reg  <= cfg_data[11:0];
                    sem_pkg::REG_FRAME_HEIGHT:  frame_height_reg <= cfg_data;
                    sem_pkg::REG_INVERT_OUTPUT: invert_reg       <= cfg_data[0];
                    default: ;
                endcase
            end
            col_reg  <= col_next;
            row_reg  <= row_next;
            pend_reg <= pend_next;
            s1_reg   <= s1_next;
            s2_reg   <= s1_reg;
            s3_reg   <= s2_reg;
            if (chain_done && chain[NCELL].emit)
                fin_valid_reg <= 1'b1;
            else if (fin_move)
                fin_valid_reg <= 1'b0;
            if (fin_move)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
            if (accept)
                busy_reg <= 1'b1;
            else if (fin_move || (chain_done && !chain[NCELL].emit))
                busy_reg <= 1'b0;
        end
    end

    // Checks
    a_one_in_chain: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(chain_valid))
        else $error("more than one request in the root chain");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (chain_valid == '0 && !s1_reg.valid && !s2_reg.valid && !s3_reg.valid))
        else $error("pipeline active while input is free");

    a_last_border: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.frame_last) |->
        (result.magnitude == (invert_reg ? sem_pkg::MAG_MAX : '0)))
        else $error("frame_last result not a border value");

    a_fin_busy: assert property (@(posedge clk) disable iff (!rst_n)
        fin_valid_reg |-> busy_reg)
        else $error("result staged with no request in flight");

endmodule
`default_nettype wire

// File: test/sobel_edge_magnitude_stream_test.sv
// Self-checking bench for sobel_edge_magnitude_stream: drives pixel and drain
// requests, predicts every edge magnitude, and checks results in order.
// Depends on sem_pkg and the block RTL.
`timescale 1ns / 1ps

module sobel_edge_magnitude_stream_test;

    localparam int LINE_DEPTH = 2048;
    localparam int HEIGHT_CAP = 4096;
    localparam int SETTLE_CYCLES = 30;

    // Predicts the magnitude stream and holds the results still owed
    class edge_scoreboard;
        int unsigned frame_w;
        int unsigned frame_h;
        bit invert;
        logic [7:0] upper_row [LINE_DEPTH];
        logic [7:0] middle_row [LINE_DEPTH];
        logic [7:0] win [9];
        int unsigned col;
        int unsigned row;
        int unsigned pending;
        sem_pkg::result_t owed [$];
        int errors;

        function new();
            frame_w = 640;
            frame_h = 480;
            invert = 0;
            foreach (upper_row[i]) upper_row[i] = '0;
            foreach (middle_row[i]) middle_row[i] = '0;
            foreach (win[i]) win[i] = '0;
            col = 0;
            row = 0;
            pending = 0;
            errors = 0;
        endfunction

        function int unsigned eff_w();
            if (frame_w < 1) return 1;
            if (frame_w > LINE_DEPTH) return LINE_DEPTH;
            return frame_w;
        endfunction

        function int unsigned eff_h();
            if (frame_h < 1) return 1;
            if (frame_h > HEIGHT_CAP) return HEIGHT_CAP;
            return frame_h;
        endfunction

        function void write_reg(logic [sem_pkg::CFG_IDX_W-1:0] idx,
                                logic [sem_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                sem_pkg::REG_FRAME_WIDTH:   frame_w = data[11:0];
                sem_pkg::REG_FRAME_HEIGHT:  frame_h = data[12:0];
                sem_pkg::REG_INVERT_OUTPUT: invert = data[0];
                default: ;
            endcase
        endfunction

        function logic [7:0] shade(int unsigned m);
            if (m > 255) m = 255;
            return invert ? 8'(255 - m) : 8'(m);
        endfunction

        // Floor square root, one root bit at a time
        function int unsigned isqrt(int unsigned v);
            int unsigned root;
            root = 0;
            for (int b = 11; b >= 0; b--)
                if ((root | (1 << b)) * (root | (1 << b)) <= v) root |= (1 << b);
            return root;
        endfunction

        function int unsigned sobel();
            int gx;
            int gy;
            gx = -int'(win[0]) + int'(win[2]) - 2 * int'(win[3]) + 2 * int'(win[5])
                 - int'(win[6]) + int'(win[8]);
            gy = -int'(win[0]) - 2 * int'(win[1]) - int'(win[2]) + int'(win[6])
                 + 2 * int'(win[7]) + int'(win[8]);
            return isqrt(gx * gx + gy * gy);
        endfunction

        function void note_request(sem_pkg::pixel_t p);
            int unsigned w;
            int unsigned h;
            int unsigned gray;
            int unsigned idx;
            logic [7:0] up;
            logic [7:0] mid;
            sem_pkg::result_t r;
            w = eff_w();
            h = eff_h();
            if (p.op == sem_pkg::OP_DRAIN) begin
                // drains only count at frame start with results owed
                if (row == 0 && col == 0 && pending != 0) begin
                    pending--;
                    r.magnitude = shade(0);
                    r.frame_last = (pending == 0);
                    owed.push_back(r);
                end
                return;
            end
            gray = (p.red >> 2) + (p.green >> 1) + (p.blue >> 3);
            idx = col % LINE_DEPTH;
            up = upper_row[idx];
            mid = middle_row[idx];
            if (row == 0 && col == 0) pending = 0;
            upper_row[idx] = mid;
            middle_row[idx] = 8'(gray);
            for (int i = 0; i < 3; i++) begin
                win[i*3] = win[i*3+1];
                win[i*3+1] = win[i*3+2];
            end
            win[2] = up;
            win[5] = mid;
            win[8] = 8'(gray);
            pending++;
            if (pending > w + 1) begin
                r.magnitude = shade((row >= 2 && col >= 2 && col < w && row < h) ? sobel() : 0);
                r.frame_last = 1'b0;
                owed.push_back(r);
                pending--;
            end
            if (col + 1 >= w) begin
                col = 0;
                row = (row + 1 >= h) ? 0 : row + 1;
            end else begin
                col = col + 1;
            end
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(sem_pkg::result_t got);
            sem_pkg::result_t want;
            if (owed.size() == 0) begin
                report($sformatf("unexpected result mag=%0d last=%0b",
                                 got.magnitude, got.frame_last));
                return;
            end
            want = owed.pop_front();
            if (got.magnitude !== want.magnitude)
                report($sformatf("magnitude got %0d want %0d", got.magnitude, want.magnitude));
            if (got.frame_last !== want.frame_last)
                report($sformatf("frame_last got %0b want %0b",
                                 got.frame_last, want.frame_last));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic pixel_valid;
    logic pixel_ready;
    sem_pkg::pixel_t pixel;
    logic result_valid;
    logic result_ready;
    sem_pkg::result_t result;
    logic cfg_valid;
    logic cfg_ready;
    logic [sem_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [sem_pkg::CFG_DATA_W-1:0] cfg_data;

    edge_scoreboard sb;
    bit calm;
    int sent;

    sobel_edge_magnitude_stream u_top (
        .clk(clk), .rst_n(rst_n),
        .pixel_valid(pixel_valid), .pixel_ready(pixel_ready), .pixel(pixel),
        .result_valid(result_valid), .result_ready(result_ready), .result(result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Clock
    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #(12 * 2000000);
        $display("tb: failure");
        $finish;
    end

    // Result sink: random stall bursts, sampled at the rising edge
    initial
    begin
        result_ready = 0;
        forever begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                result_ready = 0;
                repeat ($urandom_range(1, 7) - 1) @(negedge clk);
            end else begin
                result_ready = 1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready) sb.check_result(result);
    end

    // One request through the pixel channel
    task automatic send_request(sem_pkg::pixel_t p);
        if (!calm && $urandom_range(0, 5) == 0) begin
            pixel_valid = 0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        pixel = p;
        pixel_valid = 1;
        do @(posedge clk); while (!pixel_ready);
        sb.note_request(p);
        sent++;
        @(negedge clk);
        pixel_valid = 0;
    endtask

    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        sem_pkg::pixel_t p;
        p.op = sem_pkg::OP_PIXEL;
        p.red = r;
        p.green = g;
        p.blue = b;
        send_request(p);
    endtask

    task automatic send_drain();
        sem_pkg::pixel_t p;
        p = sem_pkg::pixel_t'($bits(sem_pkg::pixel_t)'($urandom));
        p.op = sem_pkg::OP_DRAIN;
        send_request(p);
    endtask

    // Wait until every owed result is out and the last request has left the pipe
    task automatic settle();
        while (sb.owed.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [sem_pkg::CFG_IDX_W-1:0] idx, int unsigned data);
        cfg_index = idx;
        cfg_data = sem_pkg::CFG_DATA_W'(data);
        cfg_valid = 1;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, cfg_data);
        @(negedge clk);
        cfg_valid = 0;
    endtask

    task automatic configure(int unsigned w, int unsigned h, bit inv);
        settle();
        write_reg(sem_pkg::REG_FRAME_WIDTH, w);
        write_reg(sem_pkg::REG_FRAME_HEIGHT, h);
        write_reg(sem_pkg::REG_INVERT_OUTPUT, inv);
    endtask

    // Full frame of random pixels, optional stray drains, then some drains
    task automatic send_frame(int unsigned drains, bit strays);
        int unsigned n;
        n = sb.eff_w() * sb.eff_h();
        for (int unsigned i = 0; i < n; i++) begin
            if (strays && i != 0 && $urandom_range(0, 9) == 0) send_drain();
            case ($urandom_range(0, 5))
                0: send_pixel(8'h00, 8'h00, 8'h00);
                1: send_pixel(8'hFF, 8'hFF, 8'hFF);
                default: send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
            endcase
        end
        repeat (drains) send_drain();
    endtask

    initial
    begin
        sb = new();
        calm = 0;
        sent = 0;
        rst_n = 0;
        pixel_valid = 0;
        pixel = '0;
        cfg_valid = 0;
        cfg_index = sem_pkg::REG_FRAME_WIDTH;
        cfg_data = '0;
        repeat (4) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed: drain with nothing owed, then a 4x3 frame of extremes
        configure(4, 3, 0);
        send_drain();
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_drain();                       // mid-frame, ignored
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        for (int i = 0; i < 8; i++)
            if (i % 3 == 0) send_pixel(8'hFF, 8'hFF, 8'hFF);
            else send_pixel(8'h00, 8'h00, 8'h00);
        repeat (sb.pending) send_drain();
        send_drain();                       // nothing left, ignored
        // inverted output, and a frame dropped by a new one
        configure(4, 3, 1);
        send_frame(2, 0);
        send_frame(sb.pending, 0);
        // zero sizes clamp to one pixel
        configure(0, 0, 0);
        send_frame(sb.pending, 0);
        // oversized width and height clamp; a short stretch owes no result yet
        configure(4095, 8191, 1);
        for (int i = 0; i < 24; i++)
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        configure(1, 1, 0);
        send_frame(0, 0);
        repeat (sb.pending) send_drain();

        // Random frames, mostly well formed
        while (sent < 950) begin
            if (sent > 800) calm = 1;
            if ($urandom_range(0, 2) == 0 || sb.pending != 0 && $urandom_range(0, 1) == 0)
            begin
                if (sb.pending == 0)
                    configure($urandom_range(1, 8), $urandom_range(1, 6), $urandom_range(0, 1));
            end
            if ($urandom_range(0, 7) == 0)
                send_frame($urandom_range(0, sb.pending), 1);   // may leave results owed
            else
                send_frame(0, $urandom_range(0, 3) == 0);
            if ($urandom_range(0, 7) != 0) repeat (sb.pending) send_drain();
            // hold off until everything owed has come back
            if ($urandom_range(0, 9) == 0) while (sb.owed.size() != 0) @(negedge clk);
        end
        repeat (sb.pending) send_drain();

        calm = 1;
        settle();
        if (sb.errors == 0 && sb.owed.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
